@@ rtl/core/sth_pkg.sv @@
// shared types, widths and mode codes for the segment triangle hit test
package sth_pkg;

	localparam int unsigned CoordWidthDef = 16;
	localparam int unsigned FieldWidth    = 48;

	// test modes
	typedef enum logic [1:0] {
		OP_SEGMENT       = 2'd0,
		OP_SEGMENT_FRONT = 2'd1,
		OP_LINE_FRONT    = 2'd2,
		OP_LINE_ONLY     = 2'd3
	} op_t;

	// per-item flags handed from front to back
	typedef struct packed {
		op_t  op;
		logic crosses;
		logic against;
		logic dir_nz;
	} flags_t;

endpackage

@@ rtl/core/sth_front.sv @@
// front part: unpack, offsets, plane tests and cross products (two stages)
module sth_front #(
	parameter int unsigned COORD_WIDTH = sth_pkg::CoordWidthDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      operation,
	input  logic [sth_pkg::FieldWidth-1:0]  vertex_a,
	input  logic [sth_pkg::FieldWidth-1:0]  vertex_b,
	input  logic [sth_pkg::FieldWidth-1:0]  vertex_c,
	input  logic [sth_pkg::FieldWidth-1:0]  face_normal,
	input  logic [sth_pkg::FieldWidth-1:0]  seg_origin,
	input  logic [sth_pkg::FieldWidth-1:0]  seg_direction,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sth_pkg::flags_t                 out_flags,
	output logic signed [COORD_WIDTH+1:0]   out_dir [3],
	output logic signed [2*COORD_WIDTH+4:0] out_cr  [3][3]
);
	localparam int unsigned CW = COORD_WIDTH;
	localparam int unsigned OW = CW + 1;      // vertex offset width
	localparam int unsigned PW = 2 * CW + 5;  // cross product width
	localparam int unsigned DW = 2 * CW + 4;  // plane dot width

	// component extraction, bits above the field read as zero
	function automatic logic signed [CW-1:0] comp(
		input logic [sth_pkg::FieldWidth-1:0] f, input int unsigned idx);
		logic [3*CW+sth_pkg::FieldWidth-1:0] ext;
		ext = {{(3*CW){1'b0}}, f};
		return $signed(ext[idx*CW +: CW]);
	endfunction

	logic v1_q, v2_q;
	logic adv1, adv2;

	assign adv2     = !v2_q || out_ready;
	assign adv1     = !v1_q || adv2;
	assign in_ready = adv1;

	// stage 1 registers
	logic signed [OW-1:0] r_s1 [3][3];   // vertex minus origin
	logic signed [OW:0]   pa_s1 [3];     // origin plus direction minus a
	logic signed [CW-1:0] n_s1 [3];
	logic signed [CW-1:0] d_s1 [3];
	logic [1:0]           op_s1;

	// offsets
	always_ff @(posedge clk) begin
		if (in_valid && adv1) begin
			for (int k = 0; k < 3; k++) begin
				r_s1[0][k] <= OW'(comp(vertex_a, k)) - OW'(comp(seg_origin, k));
				r_s1[1][k] <= OW'(comp(vertex_b, k)) - OW'(comp(seg_origin, k));
				r_s1[2][k] <= OW'(comp(vertex_c, k)) - OW'(comp(seg_origin, k));
				n_s1[k]    <= comp(face_normal, k);
				d_s1[k]    <= comp(seg_direction, k);
			end
			op_s1 <= operation;
		end
	end

	// origin plus direction minus a, from the stage 1 offset
	always_comb begin
		for (int k = 0; k < 3; k++)
			pa_s1[k] = (OW+1)'(d_s1[k]) - (OW+1)'(r_s1[0][k]);
	end

	// plane dots and cross products
	logic signed [DW-1:0] dot_o, dot_p, dot_d;
	logic signed [PW-1:0] cr [3][3];
	always_comb begin
		dot_o = '0;
		dot_p = '0;
		dot_d = '0;
		for (int k = 0; k < 3; k++) begin
			dot_o = dot_o - DW'(n_s1[k]) * DW'(r_s1[0][k]);
			dot_p = dot_p + DW'(n_s1[k]) * DW'(pa_s1[k]);
			dot_d = dot_d + DW'(n_s1[k]) * DW'(d_s1[k]);
		end
		for (int e = 0; e < 3; e++) begin
			cr[e][0] = PW'(r_s1[e][1]) * PW'(r_s1[(e+1)%3][2])
				- PW'(r_s1[e][2]) * PW'(r_s1[(e+1)%3][1]);
			cr[e][1] = PW'(r_s1[e][2]) * PW'(r_s1[(e+1)%3][0])
				- PW'(r_s1[e][0]) * PW'(r_s1[(e+1)%3][2]);
			cr[e][2] = PW'(r_s1[e][0]) * PW'(r_s1[(e+1)%3][1])
				- PW'(r_s1[e][1]) * PW'(r_s1[(e+1)%3][0]);
		end
	end

	// stage 2 registers
	sth_pkg::flags_t       flags_s2;
	logic signed [CW+1:0]  dir_s2 [3];
	logic signed [PW-1:0]  cr_s2 [3][3];
	always_ff @(posedge clk) begin
		if (v1_q && adv2) begin
			flags_s2.op      <= sth_pkg::op_t'(op_s1);
			flags_s2.crosses <= (dot_o < 0 && dot_p > 0) || (dot_o > 0 && dot_p < 0);
			flags_s2.against <= dot_d < 0;
			flags_s2.dir_nz  <= (d_s1[0] != 0) || (d_s1[1] != 0) || (d_s1[2] != 0);
			for (int k = 0; k < 3; k++)
				dir_s2[k] <= (CW+2)'(d_s1[k]);
			cr_s2 <= cr;
		end
	end

	// valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= in_valid;
			if (adv2) v2_q <= v1_q;
		end
	end

	assign out_valid = v2_q;
	assign out_flags = flags_s2;
	assign out_dir   = dir_s2;
	assign out_cr    = cr_s2;

endmodule

@@ rtl/core/sth_queue.sv @@
// two-entry queue between front and back parts
module sth_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;
	assign rd_data  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

@@ rtl/core/sth_back.sv @@
// back part: triple products, edge signs, mode select and output register
module sth_back #(
	parameter int unsigned COORD_WIDTH = sth_pkg::CoordWidthDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sth_pkg::flags_t                 in_flags,
	input  logic signed [COORD_WIDTH+1:0]   in_dir [3],
	input  logic signed [2*COORD_WIDTH+4:0] in_cr  [3][3],
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [3:0]                      out_bits
);
	localparam int unsigned PW = 2 * COORD_WIDTH + 5;
	localparam int unsigned MW = PW + COORD_WIDTH + 2;  // product width
	localparam int unsigned TW = MW + 2;                // triple sum width

	logic v1_q, vo_q;
	logic adv1, advo;
	assign advo     = !vo_q || out_ready;
	assign adv1     = !v1_q || advo;
	assign in_ready = adv1;

	// stage 1: nine products, registered
	logic signed [MW-1:0] prod_s1 [3][3];
	sth_pkg::flags_t      flags_s1;
	always_ff @(posedge clk) begin
		if (in_valid && adv1) begin
			for (int e = 0; e < 3; e++)
				for (int k = 0; k < 3; k++)
					prod_s1[e][k] <= MW'(in_dir[k]) * MW'(in_cr[e][k]);
			flags_s1 <= in_flags;
		end
	end

	// edge signs and mode select
	logic signed [TW-1:0] tri_sum [3];
	logic [2:0]           pos;
	logic                 in_edges, hit;
	always_comb begin
		for (int e = 0; e < 3; e++) begin
			tri_sum[e] = TW'(prod_s1[e][0]) + TW'(prod_s1[e][1]) + TW'(prod_s1[e][2]);
			pos[e]     = flags_s1.dir_nz && (tri_sum[e] > 0);
		end
		in_edges = (pos == 3'b000) || (pos == 3'b111);
		unique case (flags_s1.op)
			sth_pkg::OP_SEGMENT:       hit = flags_s1.crosses && in_edges;
			sth_pkg::OP_SEGMENT_FRONT: hit = flags_s1.crosses && flags_s1.against && in_edges;
			sth_pkg::OP_LINE_FRONT:    hit = flags_s1.against && in_edges;
			sth_pkg::OP_LINE_ONLY:     hit = in_edges;
			default:                   hit = in_edges;
		endcase
	end

	// output register
	logic [3:0] res_q;
	always_ff @(posedge clk) begin
		if (v1_q && advo) res_q <= {in_edges, flags_s1.against, flags_s1.crosses, hit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= in_valid;
			if (advo) vo_q <= v1_q;
		end
	end

	assign out_valid = vo_q;
	assign out_bits  = res_q;

endmodule

@@ rtl/core/segment_triangle_hit_test.sv @@
// Segment triangle hit test top level. One item is taken per cycle unless the
// pipeline stalls; each item passes through two front stages (vertex offsets,
// then plane dots and edge cross products), a two-entry queue, one back stage
// of triple products and an output register fed by the edge sign sums and
// mode select. Both halves stall independently, so sustained throughput is
// one transaction per cycle whenever the result side keeps tready high.
module segment_triangle_hit_test #(
	parameter int unsigned COORD_WIDTH = sth_pkg::CoordWidthDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// operation, vertex_a, vertex_b, vertex_c, face_normal, seg_origin, seg_direction
	input  logic [295:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// hit, crosses_plane, faces_against, inside_edges
	output logic [7:0]   m_axis_tdata
);
	localparam int unsigned FW = sth_pkg::FieldWidth;
	localparam int unsigned PW = 2 * COORD_WIDTH + 5;
	localparam int unsigned QW = $bits(sth_pkg::flags_t) + 3 * (COORD_WIDTH + 2) + 9 * PW;

	logic                          f_valid, f_ready, q_valid, q_ready;
	sth_pkg::flags_t               f_flags, q_flags;
	logic signed [COORD_WIDTH+1:0] f_dir [3], q_dir [3];
	logic signed [PW-1:0]          f_cr [3][3], q_cr [3][3];
	logic [QW-1:0]                 q_wdata, q_rdata;
	logic [3:0]                    res;

	sth_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.operation(s_axis_tdata[1:0]),
		.vertex_a(s_axis_tdata[2 +: FW]),
		.vertex_b(s_axis_tdata[2+FW +: FW]),
		.vertex_c(s_axis_tdata[2+2*FW +: FW]),
		.face_normal(s_axis_tdata[2+3*FW +: FW]),
		.seg_origin(s_axis_tdata[2+4*FW +: FW]),
		.seg_direction(s_axis_tdata[2+5*FW +: FW]),
		.out_valid(f_valid), .out_ready(f_ready),
		.out_flags(f_flags), .out_dir(f_dir), .out_cr(f_cr)
	);

	assign q_wdata = {f_flags, f_dir[0], f_dir[1], f_dir[2],
		f_cr[0][0], f_cr[0][1], f_cr[0][2], f_cr[1][0], f_cr[1][1], f_cr[1][2],
		f_cr[2][0], f_cr[2][1], f_cr[2][2]};

	sth_queue #(.WIDTH(QW)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(q_wdata),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_rdata)
	);

	assign {q_flags, q_dir[0], q_dir[1], q_dir[2],
		q_cr[0][0], q_cr[0][1], q_cr[0][2], q_cr[1][0], q_cr[1][1], q_cr[1][2],
		q_cr[2][0], q_cr[2][1], q_cr[2][2]} = q_rdata;

	sth_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready),
		.in_flags(q_flags), .in_dir(q_dir), .in_cr(q_cr),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_bits(res)
	);

	assign m_axis_tdata = {4'b0000, res};

endmodule

@@ rtl/core/sth_checker.sv @@
// port-level checker for the hit test, bound to the top level
module sth_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [7:0]   m_axis_tdata
);
	// a stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:4] == 4'b0000)
		else $error("padding bits set");

	// hit implies inside edges
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3])
		else $error("hit without inside edges");

	// a rise of result valid implies it was not already high; accepted items are not tracked
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(m_axis_tvalid))
		else $error("spurious result");

	// input side never blocks when the output drains freely for long
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready && $past(m_axis_tready) && $past(m_axis_tready, 2)
		&& $past(m_axis_tready, 3) && $past(m_axis_tready, 4)
		&& $past(m_axis_tready, 5) && $past(m_axis_tready, 6)
		&& $past(m_axis_tready, 7) && $past(arst_n, 8) |-> s_axis_tready)
		else $error("input stalled with free output");

endmodule

bind segment_triangle_hit_test sth_checker u_sth_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

@@ verif/segment_triangle_hit_test_test.sv @@
// testbench for the segment triangle hit test: random and directed geometry against a local predictor
`timescale 1ns / 100ps

module segment_triangle_hit_test_test;

	localparam int CW = 16;

	typedef struct packed {
		logic hit;
		logic crosses;
		logic against;
		logic in_edges;
	} verdict_t;

	typedef struct {
		longint x, y, z;
	} vec_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [295:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [7:0]   m_axis_tdata;

	logic [295:0] pending_items[$];
	verdict_t     expected_verdicts[$];
	int           error_count = 0;
	int           verdict_count = 0;
	int           hit_count = 0;
	bit           hold_sender = 0;
	bit           in_taken = 0;
	int           send_gap = 0;
	int           recv_gap = 0;

	segment_triangle_hit_test DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// split a 48-bit field into signed components
	function automatic vec_t unpack_vec(logic [47:0] f);
		vec_t v;
		v.x = longint'($signed(f[CW-1:0]));
		v.y = longint'($signed(f[2*CW-1:CW]));
		v.z = longint'($signed(f[3*CW-1:2*CW]));
		return v;
	endfunction

	function automatic vec_t vdiff(vec_t a, vec_t b);
		vec_t r;
		r.x = a.x - b.x;
		r.y = a.y - b.y;
		r.z = a.z - b.z;
		return r;
	endfunction

	function automatic longint vdot(vec_t a, vec_t b);
		return a.x * b.x + a.y * b.y + a.z * b.z;
	endfunction

	// whether d . (p x q) is positive, exact at 128 bits
	function automatic bit triple_pos(vec_t d, vec_t p, vec_t q);
		logic signed [127:0] acc;
		acc = 128'(d.x) * 128'(p.y * q.z - p.z * q.y)
			+ 128'(d.y) * 128'(p.z * q.x - p.x * q.z)
			+ 128'(d.z) * 128'(p.x * q.y - p.y * q.x);
		return acc > 0;
	endfunction

	// expected verdict for one item
	function automatic verdict_t predict_verdict(logic [295:0] item);
		verdict_t     r;
		sth_pkg::op_t op;
		vec_t         va, vb, vc, n, o, d, oa, pa, ra, rb, rc;
		longint       dot_o, dot_p;
		bit           dnz;
		int           sum;
		op = sth_pkg::op_t'(item[1:0]);
		va = unpack_vec(item[49:2]);
		vb = unpack_vec(item[97:50]);
		vc = unpack_vec(item[145:98]);
		n  = unpack_vec(item[193:146]);
		o  = unpack_vec(item[241:194]);
		d  = unpack_vec(item[289:242]);
		oa = vdiff(o, va);
		pa.x = oa.x + d.x;
		pa.y = oa.y + d.y;
		pa.z = oa.z + d.z;
		dot_o = vdot(n, oa);
		dot_p = vdot(n, pa);
		r.crosses = (dot_o < 0 && dot_p > 0) || (dot_o > 0 && dot_p < 0);
		r.against = vdot(n, d) < 0;
		ra = vdiff(va, o);
		rb = vdiff(vb, o);
		rc = vdiff(vc, o);
		dnz = (d.x != 0) || (d.y != 0) || (d.z != 0);
		sum = int'(dnz && triple_pos(d, ra, rb)) + int'(dnz && triple_pos(d, rb, rc))
			+ int'(dnz && triple_pos(d, rc, ra));
		r.in_edges = (sum == 0) || (sum == 3);
		case (op)
			sth_pkg::OP_SEGMENT:       r.hit = r.crosses && r.in_edges;
			sth_pkg::OP_SEGMENT_FRONT: r.hit = r.crosses && r.against && r.in_edges;
			sth_pkg::OP_LINE_FRONT:    r.hit = r.against && r.in_edges;
			default:                   r.hit = r.in_edges;
		endcase
		return r;
	endfunction

	function automatic logic [47:0] pack_vec(int x, int y, int z);
		return {z[15:0], y[15:0], x[15:0]};
	endfunction

	function automatic logic [295:0] make_item(sth_pkg::op_t op, logic [47:0] a,
			logic [47:0] b, logic [47:0] c, logic [47:0] n, logic [47:0] o,
			logic [47:0] d);
		return {6'd0, d, o, n, c, b, a, op};
	endfunction

	function automatic logic [47:0] rand_field();
		return 48'({$urandom(), $urandom()});
	endfunction

	// small coordinate, occasionally extreme
	function automatic int rand_coord(int span);
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(0, 1) ? 32767 : -32768;
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [47:0] rand_small_vec(int span);
		return pack_vec(rand_coord(span), rand_coord(span), rand_coord(span));
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int rand_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// well-formed ray at a triangle, random sizes
	function automatic logic [295:0] rand_aimed_item();
		int          span, a0, a1, a2, b0, b1, b2, c0, c1, c2, ox, oy, oz;
		logic [47:0] a, b, c, n, o, d;
		span = $urandom_range(0, 3) == 0 ? 12000 : 200;
		a0 = rand_coord(span); a1 = rand_coord(span); a2 = rand_coord(span);
		b0 = rand_coord(span); b1 = rand_coord(span); b2 = rand_coord(span);
		c0 = rand_coord(span); c1 = rand_coord(span); c2 = rand_coord(span);
		a = pack_vec(a0, a1, a2);
		b = pack_vec(b0, b1, b2);
		c = pack_vec(c0, c1, c2);
		// roughly the normal of the triangle, scaled down and truncated to 16 bits
		n = pack_vec(((b1 - a1) * (c2 - a2) - (b2 - a2) * (c1 - a1)) >>> 10,
			((b2 - a2) * (c0 - a0) - (b0 - a0) * (c2 - a2)) >>> 10,
			((b0 - a0) * (c1 - a1) - (b1 - a1) * (c0 - a0)) >>> 10);
		if ($urandom_range(0, 3) == 0)
			n = rand_small_vec(span);
		ox = rand_coord(span); oy = rand_coord(span); oz = rand_coord(span);
		o = pack_vec(ox, oy, oz);
		// aim at the centroid with some scatter
		d = pack_vec((a0 + b0 + c0) / 3 - ox + rand_coord(span / 4),
			(a1 + b1 + c1) / 3 - oy + rand_coord(span / 4),
			(a2 + b2 + c2) / 3 - oz + rand_coord(span / 4));
		if ($urandom_range(0, 1))
			d = pack_vec(-int'($signed(d[15:0])), -int'($signed(d[31:16])),
				-int'($signed(d[47:32])));
		return make_item(sth_pkg::op_t'($urandom_range(0, 3)), a, b, c, n, o, d);
	endfunction

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_gap      <= 0;
		end else if (s_axis_tvalid && !in_taken) begin
			// hold the offered transaction
		end else if (send_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			send_gap      <= send_gap - 1;
		end else if (pending_items.size() > 0 && !hold_sender) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= pending_items.pop_front();
			send_gap      <= rand_gap();
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// accepted inputs feed the predictor
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_verdicts.push_back(predict_verdict(s_axis_tdata));
	end

	// result side back-pressure
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= 0;
		end else if (recv_gap > 0) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= recv_gap - 1;
		end else begin
			m_axis_tready <= 1'b1;
			recv_gap      <= rand_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		verdict_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = verdict_t'({m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2],
				m_axis_tdata[3]});
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result transaction %h", m_axis_tdata);
				error_count++;
			end else begin
				want = expected_verdicts.pop_front();
				if (got.hit !== want.hit) begin
					$error("hit: expected %0b actual %0b", want.hit, got.hit);
					error_count++;
				end
				if (got.crosses !== want.crosses) begin
					$error("crosses_plane: expected %0b actual %0b", want.crosses, got.crosses);
					error_count++;
				end
				if (got.against !== want.against) begin
					$error("faces_against: expected %0b actual %0b", want.against, got.against);
					error_count++;
				end
				if (got.in_edges !== want.in_edges) begin
					$error("inside_edges: expected %0b actual %0b", want.in_edges,
						got.in_edges);
					error_count++;
				end
				if (want.hit)
					hit_count++;
			end
			verdict_count++;
		end
	end

	// stimulus and end of run
	initial begin
		logic [47:0] ta, tb, tc, tn;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: a triangle in the z=0 plane hit straight through, every mode
		ta = pack_vec(-100, -100, 0);
		tb = pack_vec(100, -100, 0);
		tc = pack_vec(0, 100, 0);
		tn = pack_vec(0, 0, 1);
		for (int m = 0; m < 4; m++) begin
			pending_items.push_back(make_item(sth_pkg::op_t'(m), ta, tb, tc, tn,
				pack_vec(0, 0, 50), pack_vec(0, 0, -100)));
			pending_items.push_back(make_item(sth_pkg::op_t'(m), ta, tb, tc, tn,
				pack_vec(0, 0, -50), pack_vec(0, 0, 100)));
			// short segment that stops above the plane
			pending_items.push_back(make_item(sth_pkg::op_t'(m), ta, tb, tc, tn,
				pack_vec(0, 0, 50), pack_vec(0, 0, -10)));
			// missing to the side
			pending_items.push_back(make_item(sth_pkg::op_t'(m), ta, tb, tc, tn,
				pack_vec(500, 0, 50), pack_vec(0, 0, -100)));
		end
		// zero direction
		pending_items.push_back(make_item(sth_pkg::OP_LINE_ONLY, ta, tb, tc, tn,
			pack_vec(0, 0, 50), '0));
		// ray through a vertex, giving a degenerate edge
		pending_items.push_back(make_item(sth_pkg::OP_SEGMENT, ta, tb, tc, tn,
			pack_vec(-100, -100, 50), pack_vec(0, 0, -100)));
		// ending exactly on the plane
		pending_items.push_back(make_item(sth_pkg::OP_SEGMENT, ta, tb, tc, tn,
			pack_vec(0, 0, 50), pack_vec(0, 0, -50)));
		// all extremes
		pending_items.push_back(make_item(sth_pkg::OP_SEGMENT_FRONT, {48{1'b1}},
			{3{16'h7fff}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}}));
		pending_items.push_back(make_item(sth_pkg::OP_LINE_FRONT, {3{16'h7fff}},
			{3{16'h8000}}, '0, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}}));
		pending_items.push_back(make_item(sth_pkg::OP_LINE_ONLY, {3{16'h8000}}, '0,
			{3{16'h7fff}}, {3{16'h8000}}, '0, {48{1'b1}}));

		// let everything drain once before the random part
		wait (pending_items.size() == 0);
		hold_sender = 1'b1;
		wait (expected_verdicts.size() == 0 && !s_axis_tvalid);
		hold_sender = 1'b0;

		for (int i = 0; i < 1300; i++) begin
			if ($urandom_range(0, 4) == 0)
				pending_items.push_back(make_item(sth_pkg::op_t'($urandom_range(0, 3)),
					rand_field(), rand_field(), rand_field(), rand_field(),
					rand_field(), rand_field()));
			else
				pending_items.push_back(rand_aimed_item());
			if (i == 650) begin
				wait (pending_items.size() == 0);
				hold_sender = 1'b1;
				wait (expected_verdicts.size() == 0 && !s_axis_tvalid);
				hold_sender = 1'b0;
			end
		end
		wait (pending_items.size() == 0 && !s_axis_tvalid);
		wait (expected_verdicts.size() == 0);
		repeat (20) @(posedge clk);

		$display("checked %0d verdicts, %0d of them hits, across all four modes",
			verdict_count, hit_count);
		$display("included extreme coordinates, zero direction and degenerate edges");
		if (error_count == 0 && expected_verdicts.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
